// ----- hw/rtl/boc_pkg.sv -----
// Shared types, widths and helper functions for the bilinear over compositor.
// Used by every module of the block; depends on nothing else.
package boc_pkg;

    localparam int NUM_CH     = 4;
    localparam int CH_W       = 16;
    localparam int NARROW_W   = 8;
    localparam int PIX_W      = NUM_CH * CH_W;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int CFG_FRAC_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = CH_W + FRAC_W;
    localparam int BPROD_W    = 2 * CH_W;
    localparam int CMP_W      = (FRAC_W > CFG_FRAC_W) ? FRAC_W : CFG_FRAC_W;

    localparam logic [FRAC_W-1:0] FRAC_ONE  = FRAC_W'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [CH_W-1:0]   CH_MAX     = {CH_W{1'b1}};
    localparam logic [CH_W-1:0]   NARROW_MAX = CH_W'({NARROW_W{1'b1}});

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_MODE = 2'd0,
        REG_FRAC_X     = 2'd1,
        REG_FRAC_Y     = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic                  depth_mode;
        logic [CFG_FRAC_W-1:0] frac_x;
        logic [CFG_FRAC_W-1:0] frac_y;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic wide;
    } ctl_t;

    typedef logic [NUM_CH-1:0][CH_W-1:0] chan_arr_t;

    function automatic logic [FRAC_W-1:0] clamp_frac(input logic [CFG_FRAC_W-1:0] f);
        logic [CMP_W-1:0] fw;
        logic [CMP_W-1:0] one;
        fw  = CMP_W'(f);
        one = CMP_W'(FRAC_ONE);
        return (fw > one) ? FRAC_W'(one) : FRAC_W'(fw);
    endfunction

    function automatic chan_arr_t unpack_pixel(input logic [PIX_W-1:0] px,
                                               input logic wide);
        chan_arr_t ch;
        for (int c = 0; c < NUM_CH; c++) begin
            ch[c] = wide ? px[c*CH_W +: CH_W] : CH_W'(px[c*NARROW_W +: NARROW_W]);
        end
        return ch;
    endfunction

endpackage

// ----- hw/rtl/boc_cfg_regs.sv -----
// Configuration register file: depth mode and the two subpixel fractions.
// Depends on boc_pkg.
module boc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [boc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [boc_pkg::CFG_DATA_W-1:0] cfg_data,
    output boc_pkg::cfg_t                 cfg
);
    import boc_pkg::*;

    logic                  depth_mode_reg;
    logic [CFG_FRAC_W-1:0] frac_x_reg;
    logic [CFG_FRAC_W-1:0] frac_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_mode_reg <= 1'b0;
            frac_x_reg     <= '0;
            frac_y_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEPTH_MODE: depth_mode_reg <= cfg_data[0];
                REG_FRAC_X:     frac_x_reg     <= CFG_FRAC_W'(cfg_data);
                REG_FRAC_Y:     frac_y_reg     <= CFG_FRAC_W'(cfg_data);
                default:        ;
            endcase
        end
    end

    assign cfg.depth_mode = depth_mode_reg;
    assign cfg.frac_x     = frac_x_reg;
    assign cfg.frac_y     = frac_y_reg;

endmodule

// ----- hw/rtl/boc_lerp_chan.sv -----
// Bilinear interpolation of one channel over two register stages.
// Stage one holds the horizontal products, stage two the vertical ones. Depends on boc_pkg.
module boc_lerp_chan (
    input  logic                        clk,
    input  logic [boc_pkg::CH_W-1:0]    tl,
    input  logic [boc_pkg::CH_W-1:0]    tr,
    input  logic [boc_pkg::CH_W-1:0]    bl,
    input  logic [boc_pkg::CH_W-1:0]    br,
    input  logic [boc_pkg::FRAC_W-1:0]  tx,
    input  logic [boc_pkg::FRAC_W-1:0]  tx_inv,
    input  logic [boc_pkg::FRAC_W-1:0]  ty,
    input  logic [boc_pkg::FRAC_W-1:0]  ty_inv,
    output logic [boc_pkg::CH_W-1:0]    sample
);
    import boc_pkg::*;

    logic [PROD_W-1:0] p_tl_reg;
    logic [PROD_W-1:0] p_tr_reg;
    logic [PROD_W-1:0] p_bl_reg;
    logic [PROD_W-1:0] p_br_reg;
    logic [PROD_W-1:0] p_top_reg;
    logic [PROD_W-1:0] p_bot_reg;
    logic [PROD_W-1:0] top_sum;
    logic [PROD_W-1:0] bot_sum;
    logic [PROD_W-1:0] ver_sum;
    logic [CH_W-1:0]   top_val;
    logic [CH_W-1:0]   bot_val;

    always_ff @(posedge clk)
    begin
        p_tl_reg <= PROD_W'(tl) * PROD_W'(tx_inv);
        p_tr_reg <= PROD_W'(tr) * PROD_W'(tx);
        p_bl_reg <= PROD_W'(bl) * PROD_W'(tx_inv);
        p_br_reg <= PROD_W'(br) * PROD_W'(tx);
    end

    assign top_sum = p_tl_reg + p_tr_reg + ROUND_HALF;
    assign bot_sum = p_bl_reg + p_br_reg + ROUND_HALF;
    assign top_val = top_sum[FRAC_BITS +: CH_W];
    assign bot_val = bot_sum[FRAC_BITS +: CH_W];

    always_ff @(posedge clk)
    begin
        p_top_reg <= PROD_W'(top_val) * PROD_W'(ty_inv);
        p_bot_reg <= PROD_W'(bot_val) * PROD_W'(ty);
    end

    assign ver_sum = p_top_reg + p_bot_reg + ROUND_HALF;
    assign sample  = ver_sum[FRAC_BITS +: CH_W];

endmodule

// ----- hw/rtl/boc_blend.sv -----
// Premultiplied alpha over: scales the destination by inverse alpha, divides by
// the channel maximum and adds the sample, over two register stages. Depends on boc_pkg.
module boc_blend (
    input  logic                       clk,
    input  logic                       rst_n,
    input  boc_pkg::ctl_t              ctl_in,
    input  boc_pkg::chan_arr_t         sample,
    input  boc_pkg::chan_arr_t         dest,
    output logic                       out_valid,
    output logic [boc_pkg::PIX_W-1:0]  out_pixel
);
    import boc_pkg::*;

    ctl_t                           ctl3_reg;
    logic [NUM_CH-1:0][BPROD_W-1:0] prod_reg;
    chan_arr_t                      samp3_reg;
    logic [CH_W-1:0]                alpha_inv;
    logic [PIX_W-1:0]               pixel_next;
    logic [PIX_W-1:0]               pixel_reg;
    logic                           valid_reg;

    assign alpha_inv = ctl_in.wide ? (CH_MAX - sample[NUM_CH-1])
                                   : (NARROW_MAX - sample[NUM_CH-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl3_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            ctl3_reg  <= ctl_in;
            valid_reg <= ctl3_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod_reg[c] <= BPROD_W'(dest[c]) * BPROD_W'(alpha_inv);
        end
        samp3_reg <= sample;
        pixel_reg <= pixel_next;
    end

    // Division by 2^w - 1 is exact as (p + (p >> w) + 1) >> w for p up to (2^w - 1)^2.
    always_comb
    begin
        logic [BPROD_W:0]       sum16;
        logic [2*NARROW_W:0]    sum8;
        logic [2*NARROW_W-1:0]  p8;
        logic [CH_W-1:0]        q16;
        logic [NARROW_W-1:0]    q8;
        logic [CH_W-1:0]        nd16;
        logic [NARROW_W-1:0]    nd8;
        pixel_next = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum16 = (BPROD_W+1)'(prod_reg[c]) + (BPROD_W+1)'(prod_reg[c] >> CH_W)
                    + (BPROD_W+1)'(1);
            q16   = sum16[CH_W +: CH_W];
            p8    = prod_reg[c][2*NARROW_W-1:0];
            sum8  = (2*NARROW_W+1)'(p8) + (2*NARROW_W+1)'(p8 >> NARROW_W)
                    + (2*NARROW_W+1)'(1);
            q8    = sum8[NARROW_W +: NARROW_W];
            nd16  = q16 + samp3_reg[c];
            nd8   = q8 + samp3_reg[c][NARROW_W-1:0];
            if (ctl3_reg.wide)
            begin
                pixel_next[c*CH_W +: CH_W] = nd16;
            end
            else
            begin
                pixel_next[c*NARROW_W +: NARROW_W] = nd8;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

// ----- hw/rtl/bilinear_over_compositor.sv -----
// Top level of the bilinear over compositor: config registers, four channel
// interpolators and the over blend. Depends on boc_pkg and all boc_ modules.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+---------------------------------------------
//  command   | start / busy            | dest_pixel, src_top_left, src_top_right,
//            |                         | src_bottom_left, src_bottom_right
//  result    | result_valid (strobe)   | blended_pixel
//  config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One beat is taken every cycle while busy is low; each result passes through four register stages.
// The four stages are the horizontal products, the vertical products, the alpha
// product and the divide-and-add output register.
// busy is high during reset and in the first cycle after it, and low from then on.
// The receiver cannot stall, so the pipeline never holds.
module bilinear_over_compositor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [boc_pkg::PIX_W-1:0]      dest_pixel,
    input  logic [boc_pkg::PIX_W-1:0]      src_top_left,
    input  logic [boc_pkg::PIX_W-1:0]      src_top_right,
    input  logic [boc_pkg::PIX_W-1:0]      src_bottom_left,
    input  logic [boc_pkg::PIX_W-1:0]      src_bottom_right,
    output logic                           result_valid,
    output logic [boc_pkg::PIX_W-1:0]      blended_pixel,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [boc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [boc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import boc_pkg::*;

    cfg_t              cfg;
    logic              busy_reg;
    logic              accept;
    ctl_t              ctl1_reg;
    ctl_t              ctl2_reg;
    chan_arr_t         dest1_reg;
    chan_arr_t         dest2_reg;
    chan_arr_t         tl_ch;
    chan_arr_t         tr_ch;
    chan_arr_t         bl_ch;
    chan_arr_t         br_ch;
    chan_arr_t         sample;
    logic [FRAC_W-1:0] tx;
    logic [FRAC_W-1:0] ty;
    logic [FRAC_W-1:0] tx_inv;
    logic [FRAC_W-1:0] ty_inv;

    boc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign busy   = busy_reg;
    assign accept = start && !busy_reg;

    assign tx     = clamp_frac(cfg.frac_x);
    assign ty     = clamp_frac(cfg.frac_y);
    assign tx_inv = FRAC_ONE - tx;
    assign ty_inv = FRAC_ONE - ty;

    assign tl_ch = unpack_pixel(src_top_left, cfg.depth_mode);
    assign tr_ch = unpack_pixel(src_top_right, cfg.depth_mode);
    assign bl_ch = unpack_pixel(src_bottom_left, cfg.depth_mode);
    assign br_ch = unpack_pixel(src_bottom_right, cfg.depth_mode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else
        begin
            busy_reg       <= 1'b0;
            ctl1_reg.valid <= accept;
            ctl1_reg.wide  <= cfg.depth_mode;
            ctl2_reg       <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dest1_reg <= unpack_pixel(dest_pixel, cfg.depth_mode);
        dest2_reg <= dest1_reg;
    end

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_chan
        boc_lerp_chan u_lerp (
            .clk    (clk),
            .tl     (tl_ch[c]),
            .tr     (tr_ch[c]),
            .bl     (bl_ch[c]),
            .br     (br_ch[c]),
            .tx     (tx),
            .tx_inv (tx_inv),
            .ty     (ty),
            .ty_inv (ty_inv),
            .sample (sample[c])
        );
    end

    boc_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl2_reg),
        .sample    (sample),
        .dest      (dest2_reg),
        .out_valid (result_valid),
        .out_pixel (blended_pixel)
    );

    a_beat_emerges: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept, 4) |-> result_valid)
        else $error("accepted command produced no result four cycles later");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, 4))
        else $error("result strobe without a matching command");

    a_busy_drops: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy stayed high after the first cycle out of reset");

endmodule
